### design/sensor_crc8_frame_check_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sensor CRC-8 frame checker
// Shared property forms used by the checker module.
// ---------------------------------------------------------------------------
`ifndef SENSOR_CRC8_FRAME_CHECK_ASSERT_SVH
`define SENSOR_CRC8_FRAME_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SC8FC_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("sensor_crc8_frame_check: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define SC8FC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("sensor_crc8_frame_check: property violated");

`endif

### design/sc8fc_pkg.sv
// ---------------------------------------------------------------------------
// Sensor CRC-8 frame check package
// Byte modes, the CRC polynomial and the bit-level helper functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sc8fc_pkg;

    // Polynomial x^8 + x^5 + x^4 + 1.
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Meaning of each request; the fourth code is unused and ignored.
    typedef enum logic [1:0] {
        MODE_CMD  = 2'd0,
        MODE_DATA = 2'd1,
        MODE_END  = 2'd2
    } mode_t;

    // Outcome of processing one request.
    typedef struct packed {
        logic       crc_load;
        logic [7:0] crc_next;
        logic       res_valid;
        logic [7:0] res_crc;
        logic       res_match;
    } step_t;

    // Shift one byte into the CRC, most significant bit first.
    function automatic logic [7:0] crc_shift_byte(input logic [7:0] crc_in,
                                                  input logic [7:0] data);
        logic [7:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = crc[7] ^ data[i];
            crc = {crc[6:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Reverse the bit order of a byte.
    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    // Seed: status bits 0..3 land in CRC bits 7..4, low nibble zero.
    function automatic logic [7:0] crc_seed(input logic [7:0] status);
        return {status[0], status[1], status[2], status[3], 4'b0000};
    endfunction

endpackage

### design/sc8fc_crc_step.sv
// ---------------------------------------------------------------------------
// CRC step logic
// Works out the next running CRC and the frame result for one request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sc8fc_crc_step (
    input  logic [1:0]       mode,
    input  logic [7:0]       byte_value,
    input  logic [7:0]       running_crc,
    input  logic [7:0]       sensor_status,
    output sc8fc_pkg::step_t step
);
    import sc8fc_pkg::*;

    logic [7:0] final_crc;

    // The received check value is compared with the reflected CRC.
    assign final_crc = reverse8(running_crc);

    // Decode the mode and form the outcome.
    always_comb
    begin
        step.crc_load  = 1'b0;
        step.crc_next  = running_crc;
        step.res_valid = 1'b0;
        step.res_crc   = final_crc;
        step.res_match = (final_crc == byte_value);
        unique case (mode_t'(mode))
            MODE_CMD:
            begin
                step.crc_load = 1'b1;
                step.crc_next = crc_shift_byte(crc_seed(sensor_status), byte_value);
            end
            MODE_DATA:
            begin
                step.crc_load = 1'b1;
                step.crc_next = crc_shift_byte(running_crc, byte_value);
            end
            MODE_END:
            begin
                step.res_valid = 1'b1;
            end
            default:
            begin
                step.crc_load = 1'b0;
            end
        endcase
    end

endmodule

### design/sensor_crc8_frame_check.sv
// A frame-end request passes through the input register and then the result register.
// Throughput: one request per cycle; command and data bytes never stall the input.
// The input stalls only while a finished result is waiting and the output is held off.
// Reset (rst_n low, asynchronous) empties both stages, clears the running CRC
// and sets the status register to zero.
// ---------------------------------------------------------------------------
// Sensor CRC-8 frame check, top level
// Checks the CRC-8 of a sensor reply frame, one byte per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_crc8_frame_check (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration write channel (status register)
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // Input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
    input  logic [1:0] s_axis_tuser,   // [1:0] mode
    // Result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] computed_crc
    output logic       m_axis_tuser    // [0] crc_match
);
    import sc8fc_pkg::*;

    logic [7:0] status_data_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [1:0] in_mode_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_crc_reg;
    logic       out_match_reg;
    logic       out_free;
    logic       in_fire;
    logic       in_take;
    step_t      step;

    // The status register takes every write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_data_reg <= 8'h00;
        end
        else if (cfg_valid)
        begin
            status_data_reg <= cfg_data;
        end
    end

    // Per-request processing.
    sc8fc_crc_step u_step (
        .mode          (in_mode_reg),
        .byte_value    (in_byte_reg),
        .running_crc   (crc_reg),
        .sensor_status (status_data_reg),
        .step          (step)
    );

    // Stage handshake: only a frame end needs room in the result register.
    assign out_free       = !out_valid_reg || m_axis_tready;
    assign in_fire        = in_valid_reg && (!step.res_valid || out_free);
    assign s_axis_tready  = !in_valid_reg || in_fire;
    assign in_take        = s_axis_tvalid && s_axis_tready;
    assign in_valid_next  = in_take || (in_valid_reg && !in_fire);
    assign out_valid_next = (in_fire && step.res_valid) || (out_valid_reg && !m_axis_tready);
    assign crc_next       = (in_fire && step.crc_load) ? step.crc_next : crc_reg;

    // Control state and running CRC.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= 8'h00;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire && step.res_valid)
        begin
            out_crc_reg   <= step.res_crc;
            out_match_reg <= step.res_match;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_crc_reg;
    assign m_axis_tuser  = out_match_reg;

endmodule

### design/sc8fc_checker.sv
// ---------------------------------------------------------------------------
// Port checker for the sensor CRC-8 frame check
// Watches the top-level streams and flags ordering or stall faults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sensor_crc8_frame_check_assert.svh"

module sc8fc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);
    import sc8fc_pkg::*;

    logic in_end;
    logic out_wait;

    // A frame-end request was accepted at this edge.
    assign in_end = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_END);

    // A result is offered but held off by the receiver.
    assign out_wait = m_axis_tvalid && !m_axis_tready;

    // A stalled result stays offered with the same payload.
    `SC8FC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, m_axis_tvalid)
    `SC8FC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_wait, $stable({m_axis_tuser, m_axis_tdata}))

    // With no result waiting, the input side never stalls.
    `SC8FC_ASSERT_SAME(a_no_stall, clk, rst_n, !m_axis_tvalid, s_axis_tready)

    // A new result appears only after a frame-end request has passed through the input register.
    `SC8FC_ASSERT_SAME(a_res_origin, clk, rst_n, $rose(m_axis_tvalid), $past(in_end, 2))

endmodule

bind sensor_crc8_frame_check sc8fc_checker u_sc8fc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
